// File: rtl/pcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// PID controller package
// Shared types, register indexes, mode codes and fixed-point helpers for the
// clamped Q16.16 PID controller.
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int DataW   = 32;
    localparam int RegIdxW = 3;

    localparam logic [RegIdxW-1:0] REG_KP       = 3'd0;
    localparam logic [RegIdxW-1:0] REG_KI       = 3'd1;
    localparam logic [RegIdxW-1:0] REG_KD       = 3'd2;
    localparam logic [RegIdxW-1:0] REG_OUT_MIN  = 3'd3;
    localparam logic [RegIdxW-1:0] REG_OUT_MAX  = 3'd4;
    localparam logic [RegIdxW-1:0] REG_PERIOD   = 3'd5;
    localparam logic [RegIdxW-1:0] REG_ANGULAR  = 3'd6;
    localparam logic [RegIdxW-1:0] REG_INVERSE  = 3'd7;

    localparam logic [1:0] MODE_COMPUTE    = 2'd0;
    localparam logic [1:0] MODE_ACTIVATE   = 2'd1;
    localparam logic [1:0] MODE_DEACTIVATE = 2'd2;

    // One turn is 360 degrees in Q16.16, which is 45 times two to the 19.
    localparam logic signed [33:0] OneTurn  = 34'sd23592960;
    localparam logic signed [33:0] HalfTurn = 34'sd11796480;
    localparam int TurnLowBits = 19;
    localparam int TurnMod     = 45;
    localparam int ModOffset   = 8235;
    localparam int ModRecip    = 46604;
    localparam int ModShift    = 21;

    localparam logic signed [65:0] SatMax = 66'sd2147483647;
    localparam logic signed [65:0] SatMin = -66'sd2147483648;

    typedef enum logic {
        OP_SEED,
        OP_RUN
    } t_op;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [DataW-1:0]  measurement;
        logic signed [DataW-1:0]  setpoint;
        logic [DataW-1:0]         now_ms;
        logic signed [DataW-1:0]  prior_output;
    } t_in;

    typedef struct packed {
        logic signed [DataW-1:0]  drive;
        logic signed [DataW-1:0]  error_value;
    } t_out;

    typedef struct packed {
        logic signed [DataW-1:0]  kp;
        logic signed [DataW-1:0]  ki_scaled;
        logic signed [DataW-1:0]  kd_scaled;
        logic signed [DataW-1:0]  out_min;
        logic signed [DataW-1:0]  out_max;
        logic [DataW-1:0]         sample_period_ms;
        logic                     angular_mode;
        logic                     inverse_direction;
    } t_cfg;

    typedef struct packed {
        t_op                      op;
        logic signed [DataW-1:0]  err;
        logic signed [DataW-1:0]  dmeas;
        logic signed [DataW-1:0]  prior;
    } t_stage;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > SatMax) begin
            r = 32'sh7fffffff;
        end else if (v < SatMin) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_lim(input logic signed [65:0] v,
                                                     input logic signed [31:0] mn,
                                                     input logic signed [31:0] mx);
        logic signed [31:0] lo;
        logic signed [31:0] r;
        lo = (mn > mx) ? mx : mn;
        if (v > 66'(mx)) begin
            r = mx;
        end else if (v < 66'(lo)) begin
            r = lo;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Exact product, optional negation, floor shift by 16, saturation.
    function automatic logic signed [31:0] gmul(input logic signed [31:0] g,
                                                input logic signed [31:0] x,
                                                input logic               inv);
        logic signed [32:0] ge;
        logic signed [65:0] p;
        ge = inv ? -33'(g) : 33'(g);
        p  = 66'(ge) * 66'(x);
        return sat32(p >>> 16);
    endfunction

endpackage
`default_nettype wire

// File: rtl/pid_controller_clamped.sv
// ----------------------------------------------------------------------------
// Clamped PID controller, Q16.16, derivative on measurement.
// Accepts one transaction per cycle unless the output channel holds back results;
// a result passes through the operand register and then the result register.
// Synchronous active-low reset clears state, settings and flags, leaving it inactive.
// ----------------------------------------------------------------------------
`default_nettype none
module pid_controller_clamped (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire pcc_pkg::t_in                  i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output pcc_pkg::t_out                      o_out_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [pcc_pkg::RegIdxW-1:0]   i_cfg_idx,
    input  wire logic [pcc_pkg::DataW-1:0]     i_cfg_data
);

    pcc_pkg::t_cfg    r_cfg;
    pcc_pkg::t_stage  stage;
    logic             stage_valid;
    logic             stage_ready;
    logic             accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pcc_pkg::REG_KP:      r_cfg.kp                <= i_cfg_data;
                pcc_pkg::REG_KI:      r_cfg.ki_scaled         <= i_cfg_data;
                pcc_pkg::REG_KD:      r_cfg.kd_scaled         <= i_cfg_data;
                pcc_pkg::REG_OUT_MIN: r_cfg.out_min           <= i_cfg_data;
                pcc_pkg::REG_OUT_MAX: r_cfg.out_max           <= i_cfg_data;
                pcc_pkg::REG_PERIOD:  r_cfg.sample_period_ms  <= i_cfg_data;
                pcc_pkg::REG_ANGULAR: r_cfg.angular_mode      <= i_cfg_data[0];
                pcc_pkg::REG_INVERSE: r_cfg.inverse_direction <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = !stage_valid || stage_ready;
    assign accept     = i_in_valid && o_in_ready;

    pcc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_accept      (accept),
        .i_in          (i_in_data),
        .i_advance     (stage_ready),
        .o_stage       (stage),
        .o_stage_valid (stage_valid)
    );

    pcc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_stage       (stage),
        .i_stage_valid (stage_valid),
        .o_stage_ready (stage_ready),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out         (o_out_data)
    );

`ifndef SYNTH
    a_ready_implies_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> stage_valid)
        else $error("Input stalled while the operand register is empty.");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_valid && !stage_ready) |=> (stage_valid && $stable(stage)))
        else $error("Operand register changed while the gain stage was stalled.");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(stage_valid && stage.op == pcc_pkg::OP_RUN))
        else $error("Result appeared without a compute operation in the gain stage.");
`endif

endmodule
`default_nettype wire

// File: rtl/pcc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// PID controller front stage
// Decodes the command, keeps the activity flag, last measurement and last
// time, forms the error and the measurement change, and loads the operand
// register for the gain stage.
// ----------------------------------------------------------------------------
module pcc_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pcc_pkg::t_cfg  i_cfg,
    input  wire logic           i_accept,
    input  wire pcc_pkg::t_in   i_in,
    input  wire logic           i_advance,
    output pcc_pkg::t_stage     o_stage,
    output logic                o_stage_valid
);

    logic                 r_active;
    logic signed [31:0]   r_last_meas;
    logic [31:0]          r_last_time;
    pcc_pkg::t_stage      r_stage;
    logic                 r_stage_valid;

    logic                 n_active;
    logic signed [31:0]   n_last_meas;
    logic [31:0]          n_last_time;
    pcc_pkg::t_stage      n_stage;
    logic                 n_load;

    logic [31:0]          elapsed;
    logic                 period_done;
    logic signed [32:0]   diff;
    logic [13:0]          diff_hi;
    logic [18:0]          diff_lo;
    logic [14:0]          mod_x;
    logic [30:0]          mod_prod;
    logic [9:0]           mod_q;
    logic [14:0]          mod_qm;
    logic [14:0]          mod_r;
    logic signed [33:0]   resid;
    logic signed [31:0]   dmeas_wrap;
    logic signed [31:0]   dmeas;

    assign elapsed     = i_in.now_ms - r_last_time;
    assign period_done = (elapsed >= i_cfg.sample_period_ms);

    assign diff    = 33'(i_in.measurement) - 33'(r_last_meas);
    assign diff_hi = diff[32:pcc_pkg::TurnLowBits];
    assign diff_lo = diff[pcc_pkg::TurnLowBits-1:0];

    // The upper part is reduced modulo 45 with a reciprocal multiply; the
    // offset is a multiple of 45 that makes the value nonnegative.
    assign mod_x    = {diff_hi[13], diff_hi} + 15'(pcc_pkg::ModOffset);
    assign mod_prod = 31'(mod_x) * 31'(pcc_pkg::ModRecip);
    assign mod_q    = mod_prod[30:pcc_pkg::ModShift];
    assign mod_qm   = 15'(mod_q) * 15'(pcc_pkg::TurnMod);
    assign mod_r    = mod_x - mod_qm;
    assign resid    = 34'({mod_r[5:0], diff_lo});

    always_comb begin
        if (resid > pcc_pkg::HalfTurn) begin
            dmeas_wrap = 32'(resid - pcc_pkg::OneTurn);
        end else begin
            dmeas_wrap = resid[31:0];
        end
    end

    assign dmeas = i_cfg.angular_mode ? dmeas_wrap : pcc_pkg::sat32(66'(diff));

    always_comb begin
        n_active      = r_active;
        n_last_meas   = r_last_meas;
        n_last_time   = r_last_time;
        n_load        = 1'b0;
        n_stage.op    = pcc_pkg::OP_RUN;
        n_stage.err   = pcc_pkg::sat32(66'(i_in.setpoint) - 66'(i_in.measurement));
        n_stage.dmeas = dmeas;
        n_stage.prior = i_in.prior_output;
        if (i_accept) begin
            unique case (i_in.mode)
                pcc_pkg::MODE_ACTIVATE: begin
                    if (!r_active) begin
                        n_active    = 1'b1;
                        n_last_meas = i_in.measurement;
                        n_load      = 1'b1;
                        n_stage.op  = pcc_pkg::OP_SEED;
                    end
                end
                pcc_pkg::MODE_DEACTIVATE: begin
                    n_active = 1'b0;
                end
                pcc_pkg::MODE_COMPUTE: begin
                    if (r_active && period_done) begin
                        n_last_meas = i_in.measurement;
                        n_last_time = i_in.now_ms;
                        n_load      = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_last_meas   <= '0;
            r_last_time   <= '0;
            r_stage_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_last_meas <= n_last_meas;
            r_last_time <= n_last_time;
            if (n_load) begin
                r_stage_valid <= 1'b1;
            end else if (i_advance) begin
                r_stage_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage       = r_stage;
    assign o_stage_valid = r_stage_valid;

endmodule
`default_nettype wire

// File: rtl/pcc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// PID controller gain stage
// Applies the three gains, updates the clamped integral, sums and clamps the
// drive, and holds the result register toward the output channel.
// ----------------------------------------------------------------------------
module pcc_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire pcc_pkg::t_cfg    i_cfg,
    input  wire pcc_pkg::t_stage  i_stage,
    input  wire logic             i_stage_valid,
    output logic                  o_stage_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output pcc_pkg::t_out         o_out
);

    logic signed [31:0]  r_integral;
    pcc_pkg::t_out       r_out;
    logic                r_out_valid;

    logic signed [31:0]  n_integral;
    logic signed [31:0]  pterm;
    logic signed [31:0]  iterm;
    logic signed [31:0]  dterm;
    logic signed [31:0]  int_sat;
    logic signed [31:0]  int_new;
    logic signed [31:0]  seed;
    logic signed [31:0]  drive;
    logic                take;
    logic                emit;

    assign pterm = pcc_pkg::gmul(i_cfg.kp, i_stage.err, i_cfg.inverse_direction);
    assign iterm = pcc_pkg::gmul(i_cfg.ki_scaled, i_stage.err, i_cfg.inverse_direction);
    assign dterm = pcc_pkg::gmul(i_cfg.kd_scaled, i_stage.dmeas, i_cfg.inverse_direction);

    assign int_sat = pcc_pkg::sat32(66'(r_integral) + 66'(iterm));
    assign int_new = pcc_pkg::clamp_lim(66'(int_sat), i_cfg.out_min, i_cfg.out_max);
    assign drive   = pcc_pkg::clamp_lim(66'(pterm) + 66'(int_new) - 66'(dterm),
                                        i_cfg.out_min, i_cfg.out_max);
    assign seed    = pcc_pkg::clamp_lim(66'(i_stage.prior), i_cfg.out_min, i_cfg.out_max);

    assign o_stage_ready = (i_stage.op != pcc_pkg::OP_RUN) || !r_out_valid || i_out_ready;
    assign take          = i_stage_valid && o_stage_ready;
    assign emit          = take && (i_stage.op == pcc_pkg::OP_RUN);

    always_comb begin
        n_integral = r_integral;
        if (take) begin
            unique case (i_stage.op)
                pcc_pkg::OP_SEED: n_integral = seed;
                pcc_pkg::OP_RUN:  n_integral = int_new;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_integral <= n_integral;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.drive       <= drive;
            r_out.error_value <= i_stage.err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

// File: sim/pcc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller checker
// Watches the command, result and register ports of the clamped PID block,
// keeps its own copy of the controller state and settings, predicts the drive
// and error of every command that runs a computation, and compares each
// result transaction with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module pcc_checker
    import pcc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  t_in                 i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  t_out                i_out_data,
    input  logic                i_cfg_we,
    input  logic [RegIdxW-1:0]  i_cfg_idx,
    input  logic [DataW-1:0]    i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked
);

    localparam longint TurnQ      = 64'sd23592960;
    localparam longint HalfTurnQ  = 64'sd11796480;

    logic signed [31:0] kp_g;
    logic signed [31:0] ki_g;
    logic signed [31:0] kd_g;
    logic signed [31:0] lim_min;
    logic signed [31:0] lim_max;
    logic [31:0]        period_ms;
    logic               angular;
    logic               inverse;

    logic signed [31:0] integ_acc;
    logic signed [31:0] last_meas;
    logic [31:0]        last_ms;
    logic               running;

    t_out drive_expected[$];
    int   fail_total;
    int   checked_total;

    function automatic logic signed [31:0] sat_q32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] limit_drive(input longint v);
        longint hi;
        longint lo;
        hi = longint'(lim_max);
        lo = (lim_min > lim_max) ? hi : longint'(lim_min);
        if (v > hi) begin
            return lim_max;
        end else if (v < lo) begin
            return lo[31:0];
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] scale_gain(input logic signed [31:0] g,
                                                      input logic signed [31:0] x);
        longint p;
        p = longint'(g) * longint'(x);
        if (inverse) begin
            p = -p;
        end
        return sat_q32(p >>> 16);
    endfunction

    function automatic logic signed [31:0] wrap_turn(input longint d);
        longint r;
        r = d % TurnQ;
        if (r < 0) begin
            r = r + TurnQ;
        end
        if (r > HalfTurnQ) begin
            r = r - TurnQ;
        end
        return r[31:0];
    endfunction

    task automatic advance_controller(input t_in item);
        logic signed [31:0] meas;
        logic signed [31:0] sp;
        logic signed [31:0] prior;
        logic signed [31:0] err;
        logic signed [31:0] dmeas;
        logic signed [31:0] pterm;
        logic signed [31:0] iterm;
        logic signed [31:0] dterm;
        logic [31:0]        elapsed;
        longint             total;
        t_out               res;
        meas    = item.measurement;
        sp      = item.setpoint;
        prior   = item.prior_output;
        elapsed = item.now_ms - last_ms;
        case (item.mode)
            MODE_ACTIVATE: begin
                if (!running) begin
                    integ_acc = limit_drive(longint'(prior));
                    last_meas = meas;
                    running   = 1'b1;
                end
            end
            MODE_DEACTIVATE: begin
                running = 1'b0;
            end
            MODE_COMPUTE: begin
                if (running && elapsed >= period_ms) begin
                    err   = sat_q32(longint'(sp) - longint'(meas));
                    dmeas = angular ? wrap_turn(longint'(meas) - longint'(last_meas))
                                    : sat_q32(longint'(meas) - longint'(last_meas));
                    pterm = scale_gain(kp_g, err);
                    iterm = scale_gain(ki_g, err);
                    integ_acc = limit_drive(longint'(sat_q32(longint'(integ_acc)
                                                             + longint'(iterm))));
                    dterm = scale_gain(kd_g, dmeas);
                    total = longint'(pterm) + longint'(integ_acc) - longint'(dterm);
                    res.drive       = limit_drive(total);
                    res.error_value = err;
                    drive_expected.push_back(res);
                    last_meas = meas;
                    last_ms   = item.now_ms;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            kp_g      = '0;
            ki_g      = '0;
            kd_g      = '0;
            lim_min   = '0;
            lim_max   = '0;
            period_ms = '0;
            angular   = 1'b0;
            inverse   = 1'b0;
            integ_acc = '0;
            last_meas = '0;
            last_ms   = '0;
            running   = 1'b0;
            drive_expected.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (drive_expected.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending, drive %h error %h",
                                              i_out_data.drive, i_out_data.error_value));
                end else begin
                    want = drive_expected.pop_front();
                    if (i_out_data.drive !== want.drive) begin
                        report_mismatch($sformatf("drive %h, predicted %h",
                                                  i_out_data.drive, want.drive));
                    end
                    if (i_out_data.error_value !== want.error_value) begin
                        report_mismatch($sformatf("error_value %h, predicted %h",
                                                  i_out_data.error_value, want.error_value));
                    end
                    checked_total++;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_KP:      kp_g      = i_cfg_data;
                    REG_KI:      ki_g      = i_cfg_data;
                    REG_KD:      kd_g      = i_cfg_data;
                    REG_OUT_MIN: lim_min   = i_cfg_data;
                    REG_OUT_MAX: lim_max   = i_cfg_data;
                    REG_PERIOD:  period_ms = i_cfg_data;
                    REG_ANGULAR: angular   = i_cfg_data[0];
                    REG_INVERSE: inverse   = i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                advance_controller(i_in_data);
            end
        end
        o_pending    <= drive_expected.size();
        o_fail_count <= fail_total;
        o_checked    <= checked_total;
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller testbench
// Drives command transactions and register settings into the clamped PID
// block with random gaps and result back-pressure. A directed pass covers
// activation rules, sample timing with wrap, error saturation, angular wrap,
// inverse gains and swapped limits; random phases then sweep many settings.
// ----------------------------------------------------------------------------
module tb;
    import pcc_pkg::*;

    localparam logic [1:0]         MODE_UNUSED = 2'd3;
    localparam logic signed [31:0] QMAX        = 32'sh7fffffff;
    localparam logic signed [31:0] QMIN        = 32'sh80000000;
    localparam logic signed [31:0] QONE        = 32'sh00010000;
    localparam logic signed [31:0] DEG179      = 32'sd11730944;
    localparam int                 IdlePct     = 23;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    t_in                 in_data   = '0;
    logic                out_ready = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [RegIdxW-1:0]  cfg_idx   = '0;
    logic [DataW-1:0]    cfg_data  = '0;
    logic                in_ready;
    logic                out_valid;
    t_out                out_data;
    int                  fail_count;
    int                  pending;
    int                  checked;

    logic                quiet = 1'b0;
    logic [31:0]         clock_ms = '0;
    logic [31:0]         cur_period = '0;
    int                  sent_total = 0;
    int                  setting_count = 0;

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        out_ready <= quiet || ($urandom_range(99) >= IdlePct);
    end

    pid_controller_clamped DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    pcc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    function automatic t_in make_item(input logic [1:0]         mode,
                                      input logic signed [31:0] meas,
                                      input logic signed [31:0] sp,
                                      input logic [31:0]        now,
                                      input logic signed [31:0] prior);
        t_in item;
        item.mode         = mode;
        item.measurement  = meas;
        item.setpoint     = sp;
        item.now_ms       = now;
        item.prior_output = prior;
        return item;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(7))
            0: return $urandom;
            1: return QMAX;
            2: return QMIN;
            default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(9))
            0: return QMAX;
            1: return QMIN;
            2: return '0;
            3: return $urandom;
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic t_in random_item();
        t_in item;
        int  pick;
        pick = $urandom_range(99);
        if (pick < 3) begin
            item.mode = MODE_DEACTIVATE;
        end else if (pick < 9) begin
            item.mode = MODE_ACTIVATE;
        end else if (pick < 11) begin
            item.mode = MODE_UNUSED;
        end else begin
            item.mode = MODE_COMPUTE;
            case ($urandom_range(19))
                0: clock_ms = clock_ms + $urandom;
                1: begin
                end
                default: clock_ms = clock_ms + $urandom_range(0, 2 * cur_period + 2);
            endcase
        end
        item.measurement  = rand_value();
        item.setpoint     = rand_value();
        item.now_ms       = clock_ms;
        item.prior_output = rand_value();
        return item;
    endfunction

    task automatic send_txn(input t_in item);
        while (!quiet && $urandom_range(99) < IdlePct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do begin
            @(posedge i_clk);
        end while (!in_ready);
        sent_total++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [31:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [31:0] kp, input logic [31:0] ki,
                                 input logic [31:0] kd, input logic [31:0] lo,
                                 input logic [31:0] hi, input logic [31:0] period,
                                 input logic ang, input logic inv);
        drain_results();
        write_reg(REG_KP, kp);
        write_reg(REG_KI, ki);
        write_reg(REG_KD, kd);
        write_reg(REG_OUT_MIN, lo);
        write_reg(REG_OUT_MAX, hi);
        write_reg(REG_PERIOD, period);
        write_reg(REG_ANGULAR, {31'd0, ang});
        write_reg(REG_INVERSE, {31'd0, inv});
        cfg_we     <= 1'b0;
        cur_period = period;
        setting_count++;
    endtask

    initial begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic signed [31:0] lo_lim;
        logic signed [31:0] hi_lim;
        logic [31:0]        period;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        load_settings(QONE, 32'h0000_8000, 32'h0000_4000, -32'sd6553600, 32'sd6553600,
                      32'd10, 1'b0, 1'b0);
        send_txn(make_item(MODE_COMPUTE, QONE, 2 * QONE, 32'd20, '0));
        send_txn(make_item(MODE_UNUSED, QONE, 2 * QONE, 32'd20, '0));
        send_txn(make_item(MODE_ACTIVATE, QONE, '0, 32'd0, QMAX));
        send_txn(make_item(MODE_ACTIVATE, 5 * QONE, '0, 32'd0, QMIN));
        send_txn(make_item(MODE_COMPUTE, QONE, 3 * QONE, 32'd5, '0));
        send_txn(make_item(MODE_COMPUTE, QONE, 3 * QONE, 32'd10, '0));
        send_txn(make_item(MODE_COMPUTE, QMAX, QMIN, 32'd20, '0));
        send_txn(make_item(MODE_COMPUTE, QMIN, QMAX, 32'd30, '0));
        send_txn(make_item(MODE_COMPUTE, -QONE, QONE, 32'hFFFF_FFF0, '0));
        send_txn(make_item(MODE_COMPUTE, 2 * QONE, -QONE, 32'd5, '0));
        send_txn(make_item(MODE_COMPUTE, 2 * QONE, -QONE, 32'd6, '0));
        send_txn(make_item(MODE_DEACTIVATE, '0, '0, 32'd50, '0));
        send_txn(make_item(MODE_COMPUTE, QONE, '0, 32'd100, '0));
        send_txn(make_item(MODE_ACTIVATE, '0, '0, 32'd100, QMIN));
        send_txn(make_item(MODE_COMPUTE, QONE, 7 * QONE, 32'd200, '0));

        load_settings(QMAX, QMIN, QMAX, 50 * QONE, -50 * QONE, 32'd0, 1'b1, 1'b1);
        send_txn(make_item(MODE_COMPUTE, QMIN, QMAX, 32'd200, '0));
        send_txn(make_item(MODE_COMPUTE, DEG179, '0, 32'd200, '0));
        send_txn(make_item(MODE_COMPUTE, -DEG179, '0, 32'd200, '0));
        send_txn(make_item(MODE_COMPUTE, QONE, '0, 32'd200, '0));
        send_txn(make_item(MODE_COMPUTE, -DEG179, '0, 32'd200, '0));

        load_settings(QMIN, QMAX, QMIN, QMIN, QMAX, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send_txn(make_item(MODE_COMPUTE, QONE, QMAX, 32'd198, QMAX));
        send_txn(make_item(MODE_COMPUTE, QONE, QMAX, 32'd199, QMAX));
        send_txn(make_item(MODE_COMPUTE, QMIN, QMAX, 32'd199, QMAX));

        clock_ms = 32'd1000;
        for (int p = 0; p < 10; p++) begin
            quiet <= (p == 4);
            if (p == 3) begin
                clock_ms = 32'hFFFF_F000;
            end
            case ($urandom_range(5))
                0: begin
                    lo_lim = QMIN;
                    hi_lim = QMAX;
                end
                1: begin
                    lo_lim = $urandom_range(1, 200) << 16;
                    hi_lim = -($urandom_range(1, 200) << 16);
                end
                default: begin
                    lo_lim = -($urandom_range(1, 300) << 16);
                    hi_lim = $urandom_range(1, 300) << 16;
                end
            endcase
            period = ($urandom_range(4) == 0) ? 32'd0 : $urandom_range(1, 25);
            load_settings(rand_gain(), rand_gain(), rand_gain(), lo_lim, hi_lim, period,
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            send_txn(make_item(MODE_ACTIVATE, rand_value(), rand_value(), clock_ms,
                               rand_value()));
            repeat (124) begin
                if ($urandom_range(99) == 0) begin
                    drain_results();
                end
                send_txn(random_item());
            end
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        $display("Run covered %0d command transactions under %0d register settings.",
                 sent_total, setting_count);
        $display("%0d computed results were compared with the prediction.", checked);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
